@@ rtl/core/iraf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iraf_pkg
// Shared types and constants of the integer-ratio audio format converter.
// ----------------------------------------------------------------------------
package iraf_pkg;

	localparam int MAX_RATIO_DEF = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPSAMPLE_HOLD      = 3'd0,
		REG_DOWNSAMPLE_SKIP    = 3'd1,
		REG_SOURCE_WIDE        = 3'd2,
		REG_SOURCE_TWO_CHANNEL = 3'd3,
		REG_DEVICE_WIDE        = 3'd4,
		REG_DEVICE_TWO_CHANNEL = 3'd5
	} reg_idx_t;

	typedef logic signed [15:0] sample_t;

	typedef struct packed {
		logic [2:0] upsample_hold;
		logic [2:0] downsample_skip;
		logic       source_wide;
		logic       source_two_channel;
		logic       device_wide;
		logic       device_two_channel;
	} cfg_t;

	// One converted frame handed from the front stage to the output stage.
	typedef struct packed {
		logic       emit;     // frame produces results (not decimated away)
		logic [2:0] copies;   // held-frame repeats before the new frame
		sample_t    new_left;
		sample_t    new_right;
		sample_t    held_left;
		sample_t    held_right;
	} job_t;

endpackage

@@ rtl/core/iraf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iraf_if
// Valid/ready stream interfaces for source frames and device results.
// ----------------------------------------------------------------------------
interface iraf_frame_if;
	import iraf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t left_in;
	sample_t right_in;
	logic    new_sound;

	modport source (output valid, output left_in, output right_in, output new_sound,
		input ready);
	modport sink (input valid, input left_in, input right_in, input new_sound,
		output ready);
endinterface

interface iraf_result_if;
	import iraf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;
	logic    run_end;

	modport source (output valid, output left_out, output right_out, output run_end,
		input ready);
	modport sink (input valid, input left_out, input right_out, input run_end,
		output ready);
endinterface

@@ rtl/core/iraf_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iraf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module iraf_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [iraf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [iraf_pkg::CFG_DATA_W-1:0] wr_data,
	output iraf_pkg::cfg_t                  cfg
);
	import iraf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upsample_hold      <= '0;
			cfg_q.downsample_skip    <= '0;
			cfg_q.source_wide        <= 1'b0;
			cfg_q.source_two_channel <= 1'b0;
			cfg_q.device_wide        <= 1'b1;
			cfg_q.device_two_channel <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_UPSAMPLE_HOLD:      cfg_q.upsample_hold      <= wr_data;
				REG_DOWNSAMPLE_SKIP:    cfg_q.downsample_skip    <= wr_data;
				REG_SOURCE_WIDE:        cfg_q.source_wide        <= wr_data[0];
				REG_SOURCE_TWO_CHANNEL: cfg_q.source_two_channel <= wr_data[0];
				REG_DEVICE_WIDE:        cfg_q.device_wide        <= wr_data[0];
				REG_DEVICE_TWO_CHANNEL: cfg_q.device_two_channel <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/iraf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iraf_front
// Input register, sample width/channel conversion, held frame and decimation.
// ----------------------------------------------------------------------------
module iraf_front #(
	parameter int MAX_RATIO = iraf_pkg::MAX_RATIO_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  iraf_pkg::cfg_t cfg,
	iraf_frame_if.sink     frames,
	output logic           job_valid,
	output iraf_pkg::job_t job,
	input  logic           take
);
	import iraf_pkg::*;

	localparam int COPY_LIMIT = MAX_RATIO - 1;

	logic    valid_s1;
	sample_t left_s1;
	sample_t right_s1;
	logic    new_sound_s1;

	sample_t    held_left_q;
	sample_t    held_right_q;
	logic [2:0] dec_count_q;

	logic signed [16:0] wl, wr, hl, hr, sum, quarter;
	sample_t            nl, nr;
	logic [2:0]         dec_eff;
	logic               move;

	function automatic logic signed [16:0] widen(input sample_t raw, input logic src_wide,
			input logic dev_wide);
		logic signed [16:0] s;
		if (src_wide) begin
			// narrow device keeps the high byte, zero-extended
			s = dev_wide ? {raw[15], raw} : {9'b0, raw[15:8]};
		end else begin
			s = dev_wide ? {raw[7], raw[7:0], 8'b0} : {{9{raw[7]}}, raw[7:0]};
		end
		return s;
	endfunction

	function automatic sample_t fit(input logic signed [16:0] v, input logic dev_wide);
		return dev_wide ? v[15:0] : {8'b0, v[7:0]};
	endfunction

	assign move         = valid_s1 && take;
	assign frames.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.valid && frames.ready) begin
			left_s1      <= frames.left_in;
			right_s1     <= frames.right_in;
			new_sound_s1 <= frames.new_sound;
		end
	end

	always_comb begin
		wl = widen(left_s1, cfg.source_wide, cfg.device_wide);
		wr = cfg.source_two_channel ? widen(right_s1, cfg.source_wide, cfg.device_wide) : wl;
		// halves truncate toward zero: add one before the shift when negative
		hl = $signed(wl + 17'(wl[16])) >>> 1;
		hr = $signed(wr + 17'(wr[16])) >>> 1;
		sum     = wl + wr;
		quarter = sum >>> 2;
		if (cfg.device_two_channel) begin
			nl = fit(hl, cfg.device_wide);
			nr = fit(hr, cfg.device_wide);
		end else begin
			nl = fit(quarter, cfg.device_wide);
			nr = '0;
		end
	end

	assign dec_eff = new_sound_s1 ? cfg.downsample_skip : dec_count_q;

	always_comb begin
		job.new_left   = nl;
		job.new_right  = nr;
		job.held_left  = new_sound_s1 ? '0 : held_left_q;
		job.held_right = new_sound_s1 ? '0 : held_right_q;
		job.emit       = (cfg.upsample_hold != '0) || (dec_eff == '0);
		if (int'(cfg.upsample_hold) > COPY_LIMIT) begin
			job.copies = 3'(COPY_LIMIT);
		end else begin
			job.copies = cfg.upsample_hold;
		end
	end

	assign job_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q  <= '0;
			held_right_q <= '0;
			dec_count_q  <= '0;
		end else if (move) begin
			held_left_q  <= nl;
			held_right_q <= nr;
			if (cfg.upsample_hold != '0) begin
				dec_count_q <= dec_eff;
			end else if (dec_eff == '0) begin
				dec_count_q <= cfg.downsample_skip;
			end else begin
				dec_count_q <= dec_eff - 3'd1;
			end
		end
	end

endmodule

@@ rtl/core/iraf_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iraf_emit
// Output register: held-frame repeats then the new frame, one a cycle if ready.
// ----------------------------------------------------------------------------
module iraf_emit #(
	parameter int MAX_RATIO = iraf_pkg::MAX_RATIO_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  iraf_pkg::job_t job,
	output logic           take,
	iraf_result_if.source  results
);
	import iraf_pkg::*;

	localparam int CLOG = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
	localparam int CW   = (CLOG > 3) ? 3 : CLOG;

	logic          out_valid_q;
	logic          out_end_q;
	sample_t       out_left_q;
	sample_t       out_right_q;
	sample_t       new_left_q;
	sample_t       new_right_q;
	logic [CW-1:0] rem_q;
	logic          xfer;

	assign xfer = results.valid && results.ready;
	// next frame may enter once the current run has its last transfer
	assign take = !out_valid_q || (results.ready && out_end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_end_q   <= 1'b0;
			rem_q       <= '0;
		end else if (take && job_valid && job.emit) begin
			out_valid_q <= 1'b1;
			if (job.copies != '0) begin
				out_end_q <= 1'b0;
				rem_q     <= CW'(job.copies - 3'd1);
			end else begin
				out_end_q <= 1'b1;
			end
		end else if (xfer) begin
			if (out_end_q) begin
				out_valid_q <= 1'b0;
			end else if (rem_q != '0) begin
				rem_q <= rem_q - CW'(1);
			end else begin
				out_end_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && job_valid && job.emit) begin
			new_left_q  <= job.new_left;
			new_right_q <= job.new_right;
			if (job.copies != '0) begin
				out_left_q  <= job.held_left;
				out_right_q <= job.held_right;
			end else begin
				out_left_q  <= job.new_left;
				out_right_q <= job.new_right;
			end
		end else if (xfer && !out_end_q && rem_q == '0) begin
			out_left_q  <= new_left_q;
			out_right_q <= new_right_q;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.left_out  = out_left_q;
	assign results.right_out = out_right_q;
	assign results.run_end   = out_end_q;

endmodule

@@ rtl/core/integer_ratio_audio_format_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_ratio_audio_format_converter
// Converts source frames to device format and resamples by integer ratios.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake       Payload
// frames    in   valid/ready     left_in, right_in, new_sound
// results   out  valid/ready     left_out, right_out, run_end
// cfg       in   wr_en only      wr_index, wr_data
//
// Frame enters an input register, then the output register. Unless results
// stall: one frame per cycle when not upsampling; with upsampling a frame gives
// min(upsample_hold, MAX_RATIO-1)+1 results, one per cycle out of the output
// register. Reset clears held frame and decimation count. A stalled result
// holds the run; the input register still takes one more frame.
// ----------------------------------------------------------------------------
module integer_ratio_audio_format_converter #(
	parameter int MAX_RATIO = iraf_pkg::MAX_RATIO_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	iraf_frame_if.sink                      frames,
	iraf_result_if.source                   results,
	input  logic                            wr_en,
	input  logic [iraf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [iraf_pkg::CFG_DATA_W-1:0] wr_data
);
	import iraf_pkg::*;

	cfg_t cfg;
	job_t job;
	logic job_valid;
	logic take;

	iraf_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	iraf_front #(.MAX_RATIO(MAX_RATIO)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.frames    (frames),
		.job_valid (job_valid),
		.job       (job),
		.take      (take)
	);

	iraf_emit #(.MAX_RATIO(MAX_RATIO)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.take      (take),
		.results   (results)
	);

	// a frame waiting in the input register stays until the output stage takes it
	a_job_holds: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !take |=> job_valid)
		else $error("input register lost a frame");

	// no new frame enters the output stage in the middle of a run
	a_no_take_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.run_end |-> !take)
		else $error("output stage taken during a run");

	// a run continues after a transfer that is not its last
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && !results.run_end |=> results.valid)
		else $error("run cut short");

	// an accepted frame is in the input register next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.ready |=> job_valid)
		else $error("accepted frame missing");

endmodule

@@ tb/tb_integer_ratio_audio_format_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_ratio_audio_format_converter
// Drives source frames through the converter under random source gaps and
// sink stalls, predicts every device result from a local copy of the held
// frame, decimation count and register settings, and checks each result in
// order. A short directed set covers the sample extremes and the corner
// configurations; random phases cover the rest.
// ----------------------------------------------------------------------------
module tb_integer_ratio_audio_format_converter;
	import iraf_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASES        = 17;
	localparam int PHASE_FRAMES  = 24;

	typedef enum logic [1:0] {OP_FRAME, OP_WRITE, OP_DRAIN} plan_kind_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    new_sound;
	} audio_frame_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    run_end;
	} device_sample_t;

	typedef struct {
		plan_kind_t   kind;
		audio_frame_t frame;
		reg_idx_t     idx;
		logic [2:0]   data;
		logic         calm;
	} plan_step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	iraf_frame_if  frames_bus();
	iraf_result_if results_bus();

	integer_ratio_audio_format_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frames   (frames_bus),
		.results  (results_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	plan_step_t     source_plan[$];
	device_sample_t predicted_samples[$];

	// local copy of the block's registers and state
	cfg_t        model_cfg;
	logic [15:0] held_left;
	logic [15:0] held_right;
	logic [2:0]  decimate_count;

	logic frame_taken;
	logic result_taken;
	logic calm_mode;
	logic plan_calm;
	logic failed;
	int   send_gap;
	int   sink_wait;
	int   quiet_cycles;
	int   stall_cycles;

	function automatic int to_device_width(input logic [15:0] raw);
		int s;
		if (model_cfg.source_wide) begin
			if (model_cfg.device_wide)
				s = int'($signed(raw));
			else
				s = int'(raw[15:8]);
		end else begin
			s = int'($signed(raw[7:0]));
			if (model_cfg.device_wide)
				s = s * 256;
		end
		return s;
	endfunction

	function automatic logic [15:0] fit_device(input int v);
		logic [31:0] u;
		u = v;
		if (model_cfg.device_wide)
			return u[15:0];
		return {8'h00, u[7:0]};
	endfunction

	function automatic void convert_frame(input audio_frame_t f);
		int l;
		int r;
		int copies;
		logic [15:0] nl;
		logic [15:0] nr;
		if (f.new_sound) begin
			held_left = '0;
			held_right = '0;
			decimate_count = model_cfg.downsample_skip;
		end
		l = to_device_width(f.left);
		r = model_cfg.source_two_channel ? to_device_width(f.right) : l;
		if (model_cfg.device_two_channel) begin
			nl = fit_device(l / 2);
			nr = fit_device(r / 2);
		end else begin
			nl = fit_device((l + r) >>> 2);
			nr = '0;
		end
		// upsampling wins over decimation when both ratios are set
		if (model_cfg.upsample_hold != 0) begin
			copies = int'(model_cfg.upsample_hold);
			if (copies > MAX_RATIO_DEF - 1)
				copies = MAX_RATIO_DEF - 1;
			for (int i = 0; i < copies; i++)
				predicted_samples.push_back('{held_left, held_right, 1'b0});
			predicted_samples.push_back('{nl, nr, 1'b1});
		end else if (decimate_count == 0) begin
			predicted_samples.push_back('{nl, nr, 1'b1});
			decimate_count = model_cfg.downsample_skip;
		end else begin
			decimate_count = decimate_count - 3'd1;
		end
		// a dropped frame still becomes the held frame
		held_left = nl;
		held_right = nr;
	endfunction

	function automatic logic [15:0] pick_sample();
		logic [15:0] raw;
		raw = 16'($urandom);
		case ($urandom_range(0, 9))
			0: raw = 16'h7fff;
			1: raw = 16'h8000;
			2: raw = 16'h0000;
			3: raw = 16'hffff;
			4: raw[7:0] = 8'h7f;
			5: raw[7:0] = 8'h80;
			default: ;
		endcase
		return raw;
	endfunction

	task automatic plan_frame(input logic [15:0] l, input logic [15:0] r, input logic ns);
		plan_step_t op;
		op.kind = OP_FRAME;
		op.frame.left = l;
		op.frame.right = r;
		op.frame.new_sound = ns;
		op.idx = REG_UPSAMPLE_HOLD;
		op.data = '0;
		op.calm = plan_calm;
		source_plan.push_back(op);
	endtask

	task automatic plan_write(input reg_idx_t idx, input logic [2:0] data);
		plan_step_t op;
		op.kind = OP_WRITE;
		op.frame = '0;
		op.idx = idx;
		op.data = data;
		op.calm = plan_calm;
		source_plan.push_back(op);
	endtask

	task automatic plan_drain();
		plan_step_t op;
		op.kind = OP_DRAIN;
		op.frame = '0;
		op.idx = REG_UPSAMPLE_HOLD;
		op.data = '0;
		op.calm = plan_calm;
		source_plan.push_back(op);
	endtask

	task automatic plan_config(input logic [2:0] hold, input logic [2:0] skip,
		input logic sw, input logic sc, input logic dw, input logic dc);
		plan_write(REG_UPSAMPLE_HOLD, hold);
		plan_write(REG_DOWNSAMPLE_SKIP, skip);
		plan_write(REG_SOURCE_WIDE, {2'b00, sw});
		plan_write(REG_SOURCE_TWO_CHANNEL, {2'b00, sc});
		plan_write(REG_DEVICE_WIDE, {2'b00, dw});
		plan_write(REG_DEVICE_TWO_CHANNEL, {2'b00, dc});
	endtask

	// source side: one step of the plan at a time, inputs change on the falling edge
	always @(negedge clk) begin
		plan_step_t op;
		logic next_valid;
		logic next_wr;
		logic block_idle;
		next_valid = frames_bus.valid;
		next_wr = 1'b0;
		if (arst_n) begin
			if (frames_bus.valid && frame_taken)
				next_valid = 1'b0;
			block_idle = predicted_samples.size() == 0 && quiet_cycles >= SETTLE_CYCLES;
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (source_plan.size() != 0) begin
					op = source_plan[0];
					case (op.kind)
						OP_FRAME: begin
							frames_bus.left_in <= op.frame.left;
							frames_bus.right_in <= op.frame.right;
							frames_bus.new_sound <= op.frame.new_sound;
							next_valid = 1'b1;
							calm_mode = op.calm;
							send_gap = op.calm ? 0 : $urandom_range(0, 9);
							void'(source_plan.pop_front());
						end
						OP_WRITE: if (block_idle) begin
							next_wr = 1'b1;
							wr_index <= op.idx;
							wr_data <= op.data;
							case (op.idx)
								REG_UPSAMPLE_HOLD:      model_cfg.upsample_hold = op.data;
								REG_DOWNSAMPLE_SKIP:    model_cfg.downsample_skip = op.data;
								REG_SOURCE_WIDE:        model_cfg.source_wide = op.data[0];
								REG_SOURCE_TWO_CHANNEL: model_cfg.source_two_channel = op.data[0];
								REG_DEVICE_WIDE:        model_cfg.device_wide = op.data[0];
								REG_DEVICE_TWO_CHANNEL: model_cfg.device_two_channel = op.data[0];
								default: ;
							endcase
							void'(source_plan.pop_front());
						end
						OP_DRAIN: if (block_idle) begin
							void'(source_plan.pop_front());
						end
						default: ;
					endcase
				end
			end
		end
		frames_bus.valid <= next_valid;
		wr_en <= next_wr;
	end

	// sink side: a fresh stall drawn after every result transfer outside calm mode
	always @(negedge clk) begin
		if (result_taken && !calm_mode)
			sink_wait = $urandom_range(0, 9);
		if (sink_wait != 0) begin
			sink_wait--;
			results_bus.ready <= 1'b0;
		end else begin
			results_bus.ready <= 1'b1;
		end
	end

	// predict on frame transfers, check on result transfers, watch for hangs
	always @(posedge clk) begin
		device_sample_t got;
		device_sample_t want;
		frame_taken = frames_bus.valid && frames_bus.ready;
		result_taken = results_bus.valid && results_bus.ready;
		if (arst_n) begin
			if (frame_taken)
				convert_frame('{frames_bus.left_in, frames_bus.right_in, frames_bus.new_sound});
			if (result_taken) begin
				got = '{results_bus.left_out, results_bus.right_out, results_bus.run_end};
				if (predicted_samples.size() == 0) begin
					$error("unexpected result: left_out %h right_out %h run_end %b",
						got.left, got.right, got.run_end);
					failed = 1'b1;
				end else begin
					want = predicted_samples.pop_front();
					if (got.left !== want.left) begin
						$error("left_out mismatch: expected %h, got %h", want.left, got.left);
						failed = 1'b1;
					end
					if (got.right !== want.right) begin
						$error("right_out mismatch: expected %h, got %h", want.right, got.right);
						failed = 1'b1;
					end
					if (got.run_end !== want.run_end) begin
						$error("run_end mismatch: expected %b, got %b", want.run_end, got.run_end);
						failed = 1'b1;
					end
				end
			end
			if (frame_taken || result_taken || frames_bus.valid) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (frame_taken || result_taken) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0] hold;
		logic [2:0] skip;
		int phase;
		int n;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		frames_bus.valid = 1'b0;
		frames_bus.left_in = '0;
		frames_bus.right_in = '0;
		frames_bus.new_sound = 1'b0;
		results_bus.ready = 1'b0;
		model_cfg = '{3'd0, 3'd0, 1'b0, 1'b0, 1'b1, 1'b1};
		held_left = '0;
		held_right = '0;
		decimate_count = '0;
		frame_taken = 1'b0;
		result_taken = 1'b0;
		calm_mode = 1'b0;
		plan_calm = 1'b0;
		failed = 1'b0;
		send_gap = 0;
		sink_wait = 0;
		quiet_cycles = 0;
		stall_cycles = 0;

		// reset settings: 8-bit mono source into a 16-bit stereo device
		plan_frame(16'h007f, 16'h1111, 1'b1);
		plan_frame(16'h0080, 16'h2222, 1'b0);
		plan_frame(16'hff80, 16'h0000, 1'b0);
		plan_frame(16'h7fff, 16'h8000, 1'b0);
		// 16-bit stereo source, 8-bit mono device
		plan_config(3'd0, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0);
		plan_frame(16'h7fff, 16'h7fff, 1'b1);
		plan_frame(16'h8000, 16'h8000, 1'b0);
		plan_frame(16'h7fff, 16'h8000, 1'b0);
		plan_frame(16'hffff, 16'h0001, 1'b0);
		// both ratios set: upsample by eight, decimation has no effect
		plan_config(3'd7, 3'd3, 1'b1, 1'b1, 1'b1, 1'b1);
		plan_frame(16'h1234, 16'hedcb, 1'b1);
		plan_frame(16'h8000, 16'h7fff, 1'b0);
		plan_frame(16'h7fff, 16'h8000, 1'b0);
		// skip rewritten: count keeps running until the next new sound
		plan_config(3'd0, 3'd2, 1'b0, 1'b1, 1'b1, 1'b0);
		for (n = 0; n < 9; n++)
			plan_frame(pick_sample(), pick_sample(), n == 4);
		// held frame must reflect the frames that were dropped
		plan_config(3'd2, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1);
		plan_frame(16'h0081, 16'h0000, 1'b0);
		plan_frame(16'h007e, 16'h0000, 1'b0);

		for (phase = 0; phase < PHASES; phase++) begin
			hold = ($urandom_range(0, 1) != 0) ? 3'd0 : 3'($urandom_range(1, 7));
			skip = 3'($urandom_range(0, 7));
			case (phase)
				0: begin hold = 3'd7; skip = 3'd0; end
				1: begin hold = 3'd0; skip = 3'd7; end
				2: begin hold = 3'd7; skip = 3'd7; end
				default: ;
			endcase
			plan_calm = (phase % 4) == 3;
			plan_config(hold, skip, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			for (n = 0; n < PHASE_FRAMES; n++) begin
				if ($urandom_range(0, 39) == 0)
					plan_drain();
				plan_frame(pick_sample(), pick_sample(),
					(n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0));
			end
		end
		plan_calm = 1'b0;

		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (source_plan.size() != 0 || frames_bus.valid || predicted_samples.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failed || predicted_samples.size() != 0) begin
			$display("== FAIL ==");
		end else begin
			$display("== PASS ==");
		end
		$finish;
	end

endmodule
